>>> rtl/core/hrlt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hrlt_pkg
// Shared types and constants of the HTTP request line tokenizer: status codes,
// field widths and the result record that travels from the scanner to the
// output register.
// ============================================================================
package hrlt_pkg;

    localparam int HRLT_MAX_LINE_DEF = 4096;

    localparam int BYTE_W   = 8;
    localparam int LEN_IN_W = 13;
    localparam int FIELD_W  = 12;
    localparam int STAT_W   = 3;

    // Status codes of a result.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_SP1   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_SP2   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_SLASH = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_CRLF  = 3'd4;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd5;

    // Characters the scanner looks for.
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FIELD_W-1:0] method_length;
        logic [FIELD_W-1:0] url_start;
        logic [FIELD_W-1:0] url_length;
        logic [FIELD_W-1:0] proto_start;
        logic [FIELD_W-1:0] proto_length;
        logic [FIELD_W-1:0] version_start;
        logic [FIELD_W-1:0] version_length;
    } result_t;

endpackage

>>> rtl/core/hrlt_scanner.sv
`timescale 1ns / 1ps
// ============================================================================
// hrlt_scanner
// Per-byte scan state of one request line. On each transfer it updates the
// phase, position and token marks and, when the line ends, forms the result.
// ============================================================================
module hrlt_scanner
    import hrlt_pkg::*;
#(
    parameter int MAX_LINE = HRLT_MAX_LINE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic                line_start,
    input  logic [LEN_IN_W-1:0] line_length,
    output logic                res_valid,
    output result_t             res
);

    localparam int POS_W = $clog2(MAX_LINE);
    localparam int CMP_W = (POS_W + 1 > LEN_IN_W) ? POS_W + 1 : LEN_IN_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_LINE - 1);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_METHOD  = 3'd1;
    localparam logic [2:0] PH_URL     = 3'd2;
    localparam logic [2:0] PH_PROTO   = 3'd3;
    localparam logic [2:0] PH_VERSION = 3'd4;

    logic [2:0]          phase_reg, phase_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic [FIELD_W-1:0]  sp1_reg, sp1_next;
    logic [FIELD_W-1:0]  sp2_reg, sp2_next;
    logic [FIELD_W-1:0]  slash_reg, slash_next;
    logic                cr_pending_reg, cr_pending_next;
    logic [LEN_IN_W-1:0] limit_reg, limit_next;

    always_comb
    begin
        logic              line_end;
        logic              fail;
        logic [STAT_W-1:0] fail_code;
        logic [FIELD_W-1:0] pos_f;

        phase_next      = phase_reg;
        position_next   = position_reg;
        sp1_next        = sp1_reg;
        sp2_next        = sp2_reg;
        slash_next      = slash_reg;
        cr_pending_next = cr_pending_reg;
        limit_next      = limit_reg;
        res_valid       = 1'b0;
        res             = '0;
        line_end        = 1'b0;
        fail            = 1'b0;
        fail_code       = ST_OK;
        pos_f           = '0;

        if (in_fire)
        begin
            if (line_start)
            begin
                phase_next      = PH_METHOD;
                position_next   = '0;
                sp1_next        = '0;
                sp2_next        = '0;
                slash_next      = '0;
                cr_pending_next = 1'b0;
                limit_next      = line_length;
            end

            pos_f = FIELD_W'(position_next);

            if (phase_next != PH_IDLE)
            begin
                if (byte_value == CH_NUL)
                begin
                    fail = 1'b1;
                    unique case (phase_next)
                        PH_URL:     fail_code = ST_NO_SP2;
                        PH_PROTO:   fail_code = ST_NO_SLASH;
                        PH_VERSION: fail_code = ST_NO_CRLF;
                        default:    fail_code = ST_NO_SP1;
                    endcase
                end
                else
                begin
                    unique case (phase_next)
                        PH_METHOD:
                        begin
                            if (byte_value == CH_SPACE)
                            begin
                                sp1_next   = pos_f;
                                phase_next = PH_URL;
                            end
                        end
                        PH_URL:
                        begin
                            if (byte_value == CH_SPACE)
                            begin
                                sp2_next   = pos_f;
                                phase_next = PH_PROTO;
                            end
                        end
                        PH_PROTO:
                        begin
                            if (byte_value == CH_SLASH)
                            begin
                                slash_next      = pos_f;
                                phase_next      = PH_VERSION;
                                cr_pending_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            if (byte_value == CH_LF && cr_pending_next)
                                line_end = 1'b1;
                            else
                                cr_pending_next = (byte_value == CH_CR);
                        end
                    endcase

                    if (line_end)
                    begin
                        // The line, LF included, must fit the declared length.
                        if (CMP_W'(position_next) + CMP_W'(1) > CMP_W'(limit_next))
                        begin
                            fail      = 1'b1;
                            fail_code = ST_TOO_LONG;
                        end
                        else
                        begin
                            res_valid          = 1'b1;
                            res.status         = ST_OK;
                            res.method_length  = sp1_next;
                            res.url_start      = sp1_next + FIELD_W'(1);
                            res.url_length     = sp2_next - sp1_next - FIELD_W'(1);
                            res.proto_start    = sp2_next + FIELD_W'(1);
                            res.proto_length   = slash_next - sp2_next - FIELD_W'(1);
                            res.version_start  = slash_next + FIELD_W'(1);
                            res.version_length = pos_f - slash_next - FIELD_W'(2);
                        end
                    end
                    else if (position_next == LAST_POS)
                    begin
                        fail      = 1'b1;
                        fail_code = ST_TOO_LONG;
                    end
                    else
                    begin
                        position_next = position_next + POS_W'(1);
                    end
                end

                if (fail)
                begin
                    res_valid  = 1'b1;
                    res        = '0;
                    res.status = fail_code;
                end

                if (fail || line_end)
                begin
                    phase_next      = PH_IDLE;
                    position_next   = '0;
                    sp1_next        = '0;
                    sp2_next        = '0;
                    slash_next      = '0;
                    cr_pending_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            position_reg   <= '0;
            sp1_reg        <= '0;
            sp2_reg        <= '0;
            slash_reg      <= '0;
            cr_pending_reg <= 1'b0;
            limit_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            position_reg   <= position_next;
            sp1_reg        <= sp1_next;
            sp2_reg        <= sp2_next;
            slash_reg      <= slash_next;
            cr_pending_reg <= cr_pending_next;
            limit_reg      <= limit_next;
        end
    end

    // An idle scanner holds no position.
    a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (position_reg == '0))
        else $error("position not cleared while idle");

    // A pending CR only exists while searching for CR LF.
    a_cr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cr_pending_reg |-> (phase_reg == PH_VERSION))
        else $error("pending CR outside version phase");

    // A good result only comes from an LF after a CR in the version phase.
    a_ok_src: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_OK) |->
            (phase_reg == PH_VERSION && cr_pending_reg && !line_start
             && byte_value == CH_LF))
        else $error("good result without CR LF");

endmodule

>>> rtl/core/hrlt_out_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// hrlt_out_stage
// Result register of the tokenizer. Holds one result until the consumer
// takes it; the scanner may load it whenever the slot is free or draining.
// ============================================================================
module hrlt_out_stage
    import hrlt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t res_q
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out_valid = valid_reg;
    assign res_q     = data_reg;

    // A new result never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || out_ready))
        else $error("result register overwritten");

endmodule

>>> rtl/core/http_request_line_tokenizer.sv
`timescale 1ns / 1ps
// ============================================================================
// http_request_line_tokenizer
// Scans an HTTP request line one byte per transfer and reports the status
// plus offset and length of the method, URL, protocol name and version.
// ============================================================================
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_ready  | byte_value, line_start, line_length
//  output  | out_valid / out_ready| status, method_length, url_start,
//          |                      | url_length, proto_start, proto_length,
//          |                      | version_start, version_length
//
// The scanner state updates at the input transfer and a result, if the byte
// closes the line, lands in the output register on the same edge. One byte
// per clock is sustained; the only limit is the single-entry result register:
// input stalls only while a result is held there and out_ready is low. rst_n
// clears the scanner to idle (bytes without line_start are dropped) and
// empties the result register.
//
// A line ends with a result on an LF directly after a CR in the version
// phase, on a zero byte, or when MAX_LINE bytes have been taken. A new
// line_start in the middle of a line silently drops the open line.
module http_request_line_tokenizer
    import hrlt_pkg::*;
#(
    parameter int MAX_LINE = HRLT_MAX_LINE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic                line_start,
    input  logic [LEN_IN_W-1:0] line_length,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [STAT_W-1:0]   status,
    output logic [FIELD_W-1:0]  method_length,
    output logic [FIELD_W-1:0]  url_start,
    output logic [FIELD_W-1:0]  url_length,
    output logic [FIELD_W-1:0]  proto_start,
    output logic [FIELD_W-1:0]  proto_length,
    output logic [FIELD_W-1:0]  version_start,
    output logic [FIELD_W-1:0]  version_length
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t res_q;

    // The result register is free when empty or being drained this cycle, so
    // any byte, including one that closes a line, can be taken then.
    assign in_ready = !out_valid || out_ready;
    assign in_fire  = in_valid && in_ready;

    hrlt_scanner #(
        .MAX_LINE (MAX_LINE)
    ) u_scanner (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .byte_value  (byte_value),
        .line_start  (line_start),
        .line_length (line_length),
        .res_valid   (res_valid),
        .res         (res)
    );

    hrlt_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_q     (res_q)
    );

    assign status         = res_q.status;
    assign method_length  = res_q.method_length;
    assign url_start      = res_q.url_start;
    assign url_length     = res_q.url_length;
    assign proto_start    = res_q.proto_start;
    assign proto_length   = res_q.proto_length;
    assign version_start  = res_q.version_start;
    assign version_length = res_q.version_length;

endmodule

>>> sim/http_request_line_tokenizer_test.sv
`timescale 1ns / 1ps
// ============================================================================
// http_request_line_tokenizer_test
// Self-checking testbench for the request line tokenizer. A scoreboard
// predicts the status and token fields of every line from the bytes the
// block accepts and compares them with each output transfer. Directed lines
// cover the corner cases; random lines run under several idle mixes and one
// long output hold-off.
// ============================================================================
module http_request_line_tokenizer_test;
    import hrlt_pkg::*;

    localparam int LINE_CAP    = HRLT_MAX_LINE_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int END_SLACK   = 16;

    // Phases of the scoreboard's own line scanner.
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_METHOD,
        SCAN_URL,
        SCAN_PROTO,
        SCAN_VERSION
    } scan_phase_e;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   byte_value = '0;
    logic                line_start = 1'b0;
    logic [LEN_IN_W-1:0] line_length = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STAT_W-1:0]   status;
    logic [FIELD_W-1:0]  method_length;
    logic [FIELD_W-1:0]  url_start;
    logic [FIELD_W-1:0]  url_length;
    logic [FIELD_W-1:0]  proto_start;
    logic [FIELD_W-1:0]  proto_length;
    logic [FIELD_W-1:0]  version_start;
    logic [FIELD_W-1:0]  version_length;

    http_request_line_tokenizer #(
        .MAX_LINE(LINE_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .byte_value(byte_value),
        .line_start(line_start),
        .line_length(line_length),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .method_length(method_length),
        .url_start(url_start),
        .url_length(url_length),
        .proto_start(proto_start),
        .proto_length(proto_length),
        .version_start(version_start),
        .version_length(version_length)
    );

    // Idle percentages of the two sides, changed between test phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Hold-off request from the test sequence; the receiver process owns
    // the countdown so that the stall is measured in real cycles.
    int stall_len   = 0;
    int stall_go    = 0;
    int stall_taken = 0;
    int hold_left   = 0;

    // Scoreboard state.
    result_t     line_results[$];
    result_t     oldest_result;
    logic [7:0]  line_buf[$];
    scan_phase_e scan_phase = SCAN_IDLE;
    int unsigned scan_pos = 0;
    int unsigned sp1_pos = 0;
    int unsigned sp2_pos = 0;
    int unsigned slash_pos = 0;
    int unsigned declared_limit = 0;
    bit          cr_before = 1'b0;

    int errors = 0;
    int scanned_bytes = 0;
    int results_predicted = 0;
    int results_checked = 0;
    int cycle_count = 0;
    int status_tally[6];

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // A run that stalls forever ends here instead of hanging the simulator.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles without finishing", $time,
                     cycle_count);
            $display("http_request_line_tokenizer test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Line scanner prediction
    // ------------------------------------------------------------------
    function automatic void clear_scan();
        scan_phase = SCAN_IDLE;
        scan_pos   = 0;
        sp1_pos    = 0;
        sp2_pos    = 0;
        slash_pos  = 0;
        cr_before  = 1'b0;
    endfunction

    // Any failing line reports only its status; all token fields read zero.
    function automatic void close_with_status(input logic [STAT_W-1:0] code);
        result_t r;
        r = '0;
        r.status = code;
        line_results.push_back(r);
        results_predicted = results_predicted + 1;
        clear_scan();
    endfunction

    // Advances the predicted scanner by one accepted byte and queues the
    // result when that byte closes the line.
    function automatic void predict_line_result(input logic [BYTE_W-1:0] b,
                                                input logic st,
                                                input logic [LEN_IN_W-1:0] len);
        result_t     r;
        int unsigned p;
        if (st)
        begin
            clear_scan();
            declared_limit = len;
            scan_phase = SCAN_METHOD;
        end
        // Bytes without a start flag are dropped while no line is open.
        if (scan_phase == SCAN_IDLE)
            return;
        scanned_bytes = scanned_bytes + 1;
        p = scan_pos;
        // A zero byte ends the string and names the token still missing.
        if (b == CH_NUL)
        begin
            case (scan_phase)
                SCAN_METHOD: close_with_status(ST_NO_SP1);
                SCAN_URL:    close_with_status(ST_NO_SP2);
                SCAN_PROTO:  close_with_status(ST_NO_SLASH);
                default:     close_with_status(ST_NO_CRLF);
            endcase
            return;
        end
        case (scan_phase)
            SCAN_METHOD:
            begin
                if (b == CH_SPACE)
                begin
                    sp1_pos = p;
                    scan_phase = SCAN_URL;
                end
            end
            SCAN_URL:
            begin
                if (b == CH_SPACE)
                begin
                    sp2_pos = p;
                    scan_phase = SCAN_PROTO;
                end
            end
            SCAN_PROTO:
            begin
                if (b == CH_SLASH)
                begin
                    slash_pos = p;
                    scan_phase = SCAN_VERSION;
                    cr_before = 1'b0;
                end
            end
            default:
            begin
                // The line ends on the first LF that directly follows a CR.
                if (b == CH_LF && cr_before)
                begin
                    if (p + 1 > declared_limit)
                        close_with_status(ST_TOO_LONG);
                    else
                    begin
                        r.status         = ST_OK;
                        r.method_length  = FIELD_W'(sp1_pos);
                        r.url_start      = FIELD_W'(sp1_pos + 1);
                        r.url_length     = FIELD_W'(sp2_pos - sp1_pos - 1);
                        r.proto_start    = FIELD_W'(sp2_pos + 1);
                        r.proto_length   = FIELD_W'(slash_pos - sp2_pos - 1);
                        r.version_start  = FIELD_W'(slash_pos + 1);
                        r.version_length = FIELD_W'(p - 2 - slash_pos);
                        line_results.push_back(r);
                        results_predicted = results_predicted + 1;
                        clear_scan();
                    end
                    return;
                end
                cr_before = (b == CH_CR);
            end
        endcase
        scan_pos = p + 1;
        if (scan_pos >= LINE_CAP)
            close_with_status(ST_TOO_LONG);
    endfunction

    // ------------------------------------------------------------------
    // Output side: receiver with random idling plus the long hold-off,
    // and the checker that compares each transfer with the oldest line.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_go != stall_taken)
        begin
            stall_taken = stall_go;
            hold_left = stall_len;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors = errors + 1;
        end
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (line_results.size() == 0)
            begin
                $display("%0t: result with no line pending, expected none, got status %0d",
                         $time, status);
                errors = errors + 1;
            end
            else
            begin
                oldest_result = line_results.pop_front();
                check_field("status", oldest_result.status, status);
                check_field("method_length", oldest_result.method_length, method_length);
                check_field("url_start", oldest_result.url_start, url_start);
                check_field("url_length", oldest_result.url_length, url_length);
                check_field("proto_start", oldest_result.proto_start, proto_start);
                check_field("proto_length", oldest_result.proto_length, proto_length);
                check_field("version_start", oldest_result.version_start, version_start);
                check_field("version_length", oldest_result.version_length,
                            version_length);
                status_tally[oldest_result.status] = status_tally[oldest_result.status] + 1;
                results_checked = results_checked + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one byte from a falling edge, after an optional random gap,
    // and holds it until the block takes it at a rising edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic st,
                             input logic [LEN_IN_W-1:0] len);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        byte_value  <= b;
        line_start  <= st;
        line_length <= len;
        do
            @(posedge clk);
        while (!in_ready);
        predict_line_result(b, st, len);
    endtask

    // Sends the assembled line; only its first byte carries the start flag
    // and the declared length, the rest carry junk in line_length.
    task automatic send_line(input int unsigned declared);
        int i;
        for (i = 0; i < line_buf.size(); i++)
        begin
            if (i == 0)
                send_byte(line_buf[i], 1'b1, LEN_IN_W'(declared));
            else
                send_byte(line_buf[i], 1'b0, LEN_IN_W'($urandom_range(0, 8191)));
        end
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (line_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void add_byte(input logic [BYTE_W-1:0] b);
        line_buf.push_back(b);
    endfunction

    // Mostly printable content, now and then any nonzero byte; never the
    // character that would end the current token.
    function automatic logic [BYTE_W-1:0] token_byte(input logic [BYTE_W-1:0] stop_char);
        logic [BYTE_W-1:0] b;
        do
        begin
            if ($urandom_range(9) == 0)
                b = BYTE_W'($urandom_range(1, 255));
            else
                b = BYTE_W'($urandom_range(8'h21, 8'h7E));
        end
        while (b == stop_char);
        return b;
    endfunction

    // Builds one random request line in line_buf and returns the declared
    // length to go with it. Most lines are complete; the rest are cut short
    // by a zero byte or left open for the next line to restart.
    function automatic int unsigned build_random_line();
        int unsigned n;
        int unsigned kind;
        int unsigned cut;
        int unsigned pick;
        line_buf.delete();
        n = $urandom_range(0, 8);
        repeat (n) add_byte(token_byte(CH_SPACE));
        add_byte(CH_SPACE);
        n = ($urandom_range(15) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 12);
        repeat (n) add_byte(token_byte(CH_SPACE));
        add_byte(CH_SPACE);
        n = $urandom_range(0, 6);
        repeat (n) add_byte(token_byte(CH_SLASH));
        add_byte(CH_SLASH);
        n = $urandom_range(0, 5);
        repeat (n) add_byte(token_byte(CH_CR));
        if ($urandom_range(7) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n) add_byte(CH_CR);
        end
        add_byte(CH_CR);
        add_byte(CH_LF);

        kind = $urandom_range(99);
        if (kind >= 72 && kind < 86)
        begin
            cut = $urandom_range(0, line_buf.size() - 1);
            while (line_buf.size() > cut)
                void'(line_buf.pop_back());
            add_byte(CH_NUL);
        end
        else if (kind >= 86)
        begin
            cut = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > cut)
                void'(line_buf.pop_back());
        end

        pick = $urandom_range(99);
        if (pick < 55)
            return LINE_CAP;
        else if (pick < 70)
            return line_buf.size();
        else if (pick < 80)
            return line_buf.size() - 1;
        return $urandom_range(0, LINE_CAP);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bytes without a start flag right after reset must not open a line.
    task automatic test_ignored_bytes();
        send_byte(8'h41, 1'b0, LEN_IN_W'(LINE_CAP));
        send_byte(CH_NUL, 1'b0, '0);
        send_byte(CH_SPACE, 1'b0, '1);
        wait_results_drained();
    endtask

    task automatic test_well_formed_lines();
        line_buf.delete();
        add_text("GET /index.html HTTP/1.1");
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_line(LINE_CAP);
        // Every token empty; the declared length fits exactly.
        line_buf.delete();
        add_text("  /");
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_line(line_buf.size());
        wait_results_drained();
    endtask

    // The line ends one byte beyond the declared length, and with none.
    task automatic test_declared_length();
        line_buf.delete();
        add_text("  /");
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_line(line_buf.size() - 1);
        send_line(0);
        wait_results_drained();
    endtask

    // A zero byte in each phase, including as the very first byte.
    task automatic test_missing_tokens();
        send_byte(CH_NUL, 1'b1, LEN_IN_W'(LINE_CAP));
        line_buf.delete();
        add_text("GET");
        add_byte(CH_NUL);
        send_line(LINE_CAP);
        line_buf.delete();
        add_text("GET /");
        add_byte(CH_NUL);
        send_line(LINE_CAP);
        line_buf.delete();
        add_text("GET / HTTP");
        add_byte(CH_NUL);
        send_line(LINE_CAP);
        line_buf.delete();
        add_text("GET / HTTP/1.1");
        add_byte(CH_CR);
        add_byte(CH_NUL);
        send_line(LINE_CAP);
        wait_results_drained();
    endtask

    // CR and LF before the slash are plain content; after it a lone LF and
    // a run of CRs keep the search going until a CR is followed by LF.
    task automatic test_crlf_search();
        line_buf.delete();
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_text(" u ");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_text("H/");
        add_byte(CH_LF);
        add_byte(CH_CR);
        add_byte(8'hFF);
        add_byte(CH_CR);
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_line(LINE_CAP);
        wait_results_drained();
    endtask

    // A new start flag drops the open line; after a result, stray bytes
    // without the flag are ignored, a zero byte too.
    task automatic test_restart_mid_line();
        line_buf.delete();
        add_text("PUT /x H");
        send_line(LINE_CAP);
        line_buf.delete();
        add_text("GET /y HTTP/2");
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_line(LINE_CAP);
        send_byte(8'h80, 1'b0, '0);
        send_byte(CH_NUL, 1'b0, '0);
        wait_results_drained();
    endtask

    // Random lines with stray bytes in between, until both the byte target
    // and at least eight results are reached.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int byte_target);
        int          bytes_goal;
        int          results_goal;
        int unsigned declared;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        bytes_goal   = scanned_bytes + byte_target;
        results_goal = results_predicted + 8;
        while (scanned_bytes < bytes_goal || results_predicted < results_goal)
        begin
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0,
                              LEN_IN_W'($urandom_range(0, 8191)));
            end
            declared = build_random_line();
            send_line(declared);
        end
        wait_results_drained();
    endtask

    // The receiver holds off for a long stretch while short lines keep
    // coming, so the result register fills and the input stalls.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_len = 300;
        stall_go  = stall_go + 1;
        repeat (24)
        begin
            line_buf.delete();
            add_byte($urandom_range(1) ? CH_SPACE : 8'h47);
            add_byte(CH_NUL);
            send_line($urandom_range(0, LINE_CAP));
        end
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        foreach (status_tally[i])
            status_tally[i] = 0;
        send_idle_pct = 22;
        recv_idle_pct = 60;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_ignored_bytes();
        test_well_formed_lines();
        test_declared_length();
        test_missing_tokens();
        test_crlf_search();
        test_restart_mid_line();

        test_random_traffic(22, 60, 250);
        test_random_traffic(60, 22, 250);
        test_random_traffic(0, 0, 250);
        test_output_backpressure();

        wait_results_drained();
        repeat (END_SLACK) @(posedge clk);

        $display("Scanned %0d line bytes and checked %0d lines: %0d ok, %0d too long,",
                 scanned_bytes, results_checked, status_tally[ST_OK],
                 status_tally[ST_TOO_LONG]);
        $display("%0d cut short, under three idle mixes and a 300-cycle output hold-off.",
                 results_checked - status_tally[ST_OK] - status_tally[ST_TOO_LONG]);
        if (errors == 0)
            $display("http_request_line_tokenizer test passed");
        else
            $display("http_request_line_tokenizer test failed");
        $finish;
    end

endmodule
